// ===== rtl/core/pfs_pkg.sv =====
// Package for the smallest-prime-factor sieve factorizer.
// Holds the controller state type. No dependencies.
`default_nettype none
package pfs_pkg;

  // factorizer controller states, one-hot
  typedef enum logic [8:0] {
    ST_SIEVE_RD  = 9'b000000001,
    ST_SIEVE_CHK = 9'b000000010,
    ST_MARK_RD   = 9'b000000100,
    ST_MARK_WR   = 9'b000001000,
    ST_IDLE      = 9'b000010000,
    ST_LOOK      = 9'b000100000,
    ST_DIV       = 9'b001000000,
    ST_EMIT      = 9'b010000000,
    ST_WAIT      = 9'b100000000
  } state_e;

endpackage
`default_nettype wire

// ===== rtl/core/prime_factorizer_spf_sieve_core.sv =====
// Top level of the smallest-prime-factor factorizer: sieve filler and factor loop.
// Depends on pfs_pkg, pfs_table and pfs_divider.
//
//  channel | ports                         | handshake
//  --------+-------------------------------+--------------------------
//  input   | value_i                       | start && !busy
//  result  | prime_o, exponent_o, last_o   | valid_o, one cycle, no stall
//
// Reset: a zero-fill pass over every entry, then a sieve pass that reads each entry
// and marks the multiples of each prime found, from its square; busy stays high.
// Per item: an accept, a lookup, then per division a divider run, a wait state and
// a new lookup, plus an EMIT state for each distinct prime after the first lookup.
// An input below two gives its result the cycle after acceptance, busy stays low.
// Results leave on a one-cycle strobe; the receiver cannot stall them.
`default_nettype none
module prime_factorizer_spf_sieve_core #(
  parameter int unsigned VALUE_BITS = 16
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  start,
  output logic                       busy,
  input  wire logic [15:0]           value_i,
  output logic                       valid_o,
  output logic [15:0]                prime_o,
  output logic [4:0]                 exponent_o,
  output logic                       last_o
);
  localparam int unsigned W = VALUE_BITS;

  pfs_pkg::state_e state_q, state_d;
  logic [W-1:0] i_q, i_d, j_q, j_d, rest_q, rest_d, p_q, p_d;
  logic [4:0]   e_q, e_d;
  logic         clr_q, clr_d;   // first pass: zero-fill sweep
  logic         we;
  logic [W-1:0] addr, wdata, rdata;
  logic         div_start, div_done;
  logic [W-1:0] quot;
  logic [2*W-1:0] sq;
  logic [W:0]   jn;
  logic         v_d;
  logic [15:0]  pr_d;
  logic [4:0]   ex_d;
  logic         la_d;

  pfs_table #(.W(W)) u_table (
    .clk_i, .we_i(we), .addr_i(addr), .wdata_i(wdata), .rdata_o(rdata)
  );

  pfs_divider #(.W(W)) u_div (
    .clk_i, .rst_ni, .start_i(div_start), .dividend_i(rest_q), .divisor_i(p_q),
    .done_o(div_done), .quot_o(quot)
  );

  assign sq = i_q * i_q;
  assign jn = {1'b0, j_q} + {1'b0, i_q};

  // sieve sequencer and factor loop
  always_comb begin
    state_d = state_q;
    i_d = i_q; j_d = j_q; rest_d = rest_q; p_d = p_q; e_d = e_q; clr_d = clr_q;
    we = 1'b0; addr = i_q; wdata = '0; div_start = 1'b0;
    v_d = 1'b0; pr_d = 16'(p_q); ex_d = e_q; la_d = 1'b0;
    unique case (state_q)
      // zero-fill pass, then sieve pass
      pfs_pkg::ST_SIEVE_RD: begin
        if (clr_q) begin
          we = 1'b1; addr = i_q;
          i_d = i_q + 1'b1;
          if (i_q == '1) begin
            clr_d = 1'b0; i_d = W'(2);
          end
        end else begin
          addr = i_q;
          state_d = pfs_pkg::ST_SIEVE_CHK;
        end
      end
      pfs_pkg::ST_SIEVE_CHK: begin
        if (rdata == '0) begin
          we = 1'b1; addr = i_q; wdata = i_q;
          if (sq[2*W-1:W] == '0) begin
            j_d = sq[W-1:0];
            state_d = pfs_pkg::ST_MARK_RD;
          end else if (i_q == '1) begin
            state_d = pfs_pkg::ST_IDLE;
          end else begin
            i_d = i_q + 1'b1; state_d = pfs_pkg::ST_SIEVE_RD;
          end
        end else if (i_q == '1) begin
          state_d = pfs_pkg::ST_IDLE;
        end else begin
          i_d = i_q + 1'b1; state_d = pfs_pkg::ST_SIEVE_RD;
        end
      end
      pfs_pkg::ST_MARK_RD: begin
        addr = j_q;
        state_d = pfs_pkg::ST_MARK_WR;
      end
      pfs_pkg::ST_MARK_WR: begin
        addr = j_q;
        if (rdata == '0) begin
          we = 1'b1; wdata = i_q;
        end
        if (jn[W]) begin
          i_d = i_q + 1'b1; state_d = pfs_pkg::ST_SIEVE_RD;
        end else begin
          j_d = jn[W-1:0]; state_d = pfs_pkg::ST_MARK_RD;
        end
      end
      // accept an item
      pfs_pkg::ST_IDLE: begin
        if (start) begin
          rest_d = W'(value_i);
          if (W'(value_i) < W'(2)) begin
            v_d = 1'b1; pr_d = '0; ex_d = '0; la_d = 1'b1;
          end else begin
            addr = W'(value_i); p_d = '0; e_d = '0;
            state_d = pfs_pkg::ST_LOOK;
          end
        end
      end
      // table data for rest is ready
      pfs_pkg::ST_LOOK: begin
        if (rest_q != W'(1) && rdata == p_q) begin
          div_start = 1'b1; state_d = pfs_pkg::ST_DIV;
        end else begin
          // close the run of p; start a new one unless rest is one
          if (e_q != '0) begin
            v_d = 1'b1; la_d = (rest_q == W'(1));
          end
          if (rest_q == W'(1)) begin
            state_d = pfs_pkg::ST_IDLE;
          end else begin
            p_d = rdata; e_d = '0;
            div_start = 1'b0;
            state_d = pfs_pkg::ST_EMIT;
          end
        end
      end
      pfs_pkg::ST_EMIT: begin
        div_start = 1'b1; state_d = pfs_pkg::ST_DIV;
      end
      pfs_pkg::ST_DIV: begin
        if (div_done) begin
          rest_d = quot; e_d = e_q + 1'b1;
          addr = quot; state_d = pfs_pkg::ST_WAIT;
        end
      end
      pfs_pkg::ST_WAIT: begin
        addr = rest_q; state_d = pfs_pkg::ST_LOOK;
      end
      default: state_d = pfs_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= pfs_pkg::ST_SIEVE_RD;
      i_q     <= '0;
      clr_q   <= 1'b1;
      valid_o <= 1'b0;
    end else begin
      state_q <= state_d;
      i_q     <= i_d;
      clr_q   <= clr_d;
      valid_o <= v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    j_q <= j_d; rest_q <= rest_d; p_q <= p_d; e_q <= e_d;
    prime_o <= pr_d; exponent_o <= ex_d; last_o <= la_d;
  end

  assign busy = (state_q != pfs_pkg::ST_IDLE);
endmodule
`default_nettype wire

// ===== rtl/core/pfs_divider.sv =====
// Restoring divider for the factorizer: quotient, one bit per cycle.
// Uses no package items.
`default_nettype none
module pfs_divider #(
  parameter int unsigned W = 16
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         start_i,
  input  wire logic [W-1:0] dividend_i,
  input  wire logic [W-1:0] divisor_i,
  output logic              done_o,
  output logic [W-1:0]      quot_o
);
  localparam int unsigned CW = $clog2(W + 1);

  logic [W-1:0]  quot_q, quot_d, rem_q, rem_d, dvs_q, dvs_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          busy_q, busy_d, done_q, done_d;
  logic [W:0]    trial;

  // one shift-subtract step per cycle
  always_comb begin
    quot_d = quot_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    trial  = {rem_q, quot_q[W-1]} - {1'b0, dvs_q};
    if (start_i) begin
      quot_d = dividend_i;
      rem_d  = '0;
      dvs_d  = divisor_i;
      cnt_d  = CW'(W);
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (trial[W]) begin
        rem_d = {rem_q[W-2:0], quot_q[W-1]};
        quot_d = {quot_q[W-2:0], 1'b0};
      end else begin
        rem_d = trial[W-1:0];
        quot_d = {quot_q[W-2:0], 1'b1};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quot_q <= quot_d;
    rem_q  <= rem_d;
    dvs_q  <= dvs_d;
  end

  assign done_o = done_q;
  assign quot_o = quot_q;
endmodule
`default_nettype wire

// ===== rtl/core/pfs_table.sv =====
// Smallest-prime-factor table: one synchronous RAM, one port, registered read.
// Uses no package items.
`default_nettype none
module pfs_table #(
  parameter int unsigned W = 16
) (
  input  wire logic         clk_i,
  input  wire logic         we_i,
  input  wire logic [W-1:0] addr_i,
  input  wire logic [W-1:0] wdata_i,
  output logic [W-1:0]      rdata_o
);
  logic [W-1:0] mem_q [2**W];

  // write, and registered read of the old contents
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end
endmodule
`default_nettype wire

// ===== tb/prime_factorizer_spf_sieve_core_tb.sv =====
// Testbench for prime_factorizer_spf_sieve_core: directed and random values,
// factor results checked against a trial-division predictor. Uses no package types.
`timescale 1ns / 100ps
module prime_factorizer_spf_sieve_core_tb;

  localparam int unsigned QuietLimit = 2000000;  // sieve after reset is the long pole
  localparam int unsigned DrainCycles = 600;
  localparam int unsigned RandomItems = 150;
  localparam int unsigned ReportMax = 10;

  typedef struct packed {
    logic [15:0] prime;
    logic [4:0]  exponent;
    logic        last;
  } factor_t;

  logic        clk_i;
  logic        rst_ni;
  logic        start;
  logic        busy;
  logic [15:0] value_i;
  logic        valid_o;
  logic [15:0] prime_o;
  logic [4:0]  exponent_o;
  logic        last_o;

  logic [15:0] pending_values[$];
  factor_t     expected_factors[$];
  int unsigned issued_cnt;
  int unsigned accepted_cnt;
  int unsigned factor_cnt;
  int unsigned mismatch_cnt;
  int unsigned quiet_cycles;
  int unsigned gap_left;
  int unsigned burst_left;

  prime_factorizer_spf_sieve_core #(.VALUE_BITS(16)) u_dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start     (start),
    .busy      (busy),
    .value_i   (value_i),
    .valid_o   (valid_o),
    .prime_o   (prime_o),
    .exponent_o(exponent_o),
    .last_o    (last_o)
  );

  // clock and reset
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    rst_ni = 1'b0;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
  end

  // factor by trial division, ascending primes, last flag on the final one
  function automatic void predict_factors(input logic [15:0] value);
    int unsigned rest;
    int unsigned p;
    int unsigned e;
    factor_t     f;
    rest = value;
    if (rest < 2) begin
      f = '{prime: 16'd0, exponent: 5'd0, last: 1'b1};
      expected_factors = {expected_factors, f};
      return;
    end
    p = 2;
    while (p * p <= rest) begin
      if (rest % p == 0) begin
        e = 0;
        while (rest % p == 0) begin
          rest = rest / p;
          e++;
        end
        f = '{prime: p[15:0], exponent: e[4:0], last: (rest == 1)};
        expected_factors = {expected_factors, f};
      end
      p++;
    end
    if (rest > 1) begin
      f = '{prime: rest[15:0], exponent: 5'd1, last: 1'b1};
      expected_factors = {expected_factors, f};
    end
  endfunction

  // random value: uniform, smooth product of small primes, or prime power
  function automatic logic [15:0] random_value();
    int unsigned small_primes[8] = '{2, 3, 5, 7, 11, 13, 17, 19};
    int unsigned v;
    int unsigned m;
    int unsigned pick;
    pick = $urandom_range(0, 3);
    if (pick < 2) return 16'($urandom());
    if (pick == 2) begin
      v = 1;
      repeat ($urandom_range(1, 12)) begin
        m = small_primes[$urandom_range(0, 7)];
        if (v * m < 65536) v = v * m;
      end
      return v[15:0];
    end
    m = small_primes[$urandom_range(0, 3)];
    v = m;
    repeat ($urandom_range(0, 15)) if (v * m < 65536) v = v * m;
    return v[15:0];
  endfunction

  // stimulus list
  initial begin
    logic [15:0] directed[$] = '{16'd0, 16'd1, 16'd2, 16'd3, 16'd4, 16'd6, 16'd65535,
      16'd65521, 16'd32768, 16'd30030, 16'd65534, 16'd49729, 16'd65025, 16'hAAAA,
      16'h5555, 16'd59049, 16'd46189, 16'd15015, 16'd1024, 16'd961};
    foreach (directed[i]) pending_values = {pending_values, directed[i]};
    repeat (RandomItems) pending_values = {pending_values, random_value()};
  end

  // driver: bursts with random gaps, inputs change on the falling edge
  initial begin
    start = 1'b0;
    value_i = '0;
    gap_left = 0;
    burst_left = 1;
  end

  always @(negedge clk_i) begin
    if (rst_ni && issued_cnt == accepted_cnt) begin
      if (gap_left > 0 || pending_values.size() == 0) begin
        start <= 1'b0;
        if (gap_left > 0) gap_left--;
      end else begin
        start <= 1'b1;
        value_i <= pending_values.pop_front();
        issued_cnt++;
        if (burst_left > 1) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(1, 8);
          gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 40);
        end
      end
    end
  end

  // monitor: accept items and check factor results on the rising edge
  always @(posedge clk_i) begin
    factor_t exp_f;
    if (rst_ni) begin
      if ((start && !busy && issued_cnt != accepted_cnt) || valid_o) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
      if (start && !busy && issued_cnt != accepted_cnt) begin
        predict_factors(value_i);
        accepted_cnt++;
      end
      if (valid_o) begin
        factor_cnt++;
        if (expected_factors.size() == 0) begin
          mismatch_cnt++;
          if (mismatch_cnt <= ReportMax)
            $display("unexpected factor: prime %0d exp %0d last %0b",
                     prime_o, exponent_o, last_o);
        end else begin
          exp_f = expected_factors.pop_front();
          if (exp_f.prime !== prime_o || exp_f.exponent !== exponent_o ||
              exp_f.last !== last_o) begin
            mismatch_cnt++;
            if (mismatch_cnt <= ReportMax)
              $display("factor mismatch: exp %0d^%0d last %0b, got %0d^%0d last %0b",
                       exp_f.prime, exp_f.exponent, exp_f.last,
                       prime_o, exponent_o, last_o);
          end
        end
      end
    end
  end

  // watchdog on cycles with no traffic
  initial begin
    quiet_cycles = 0;
    issued_cnt = 0;
    accepted_cnt = 0;
    factor_cnt = 0;
    mismatch_cnt = 0;
    wait (quiet_cycles >= QuietLimit);
    $display("timeout after %0d quiet cycles", QuietLimit);
    $display("Regression FAIL");
    $finish;
  end

  // end of run
  initial begin
    @(posedge rst_ni);
    while (pending_values.size() != 0 || issued_cnt != accepted_cnt) @(posedge clk_i);
    while (expected_factors.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    $display("%0d values factored into %0d prime results, %0d mismatches",
             accepted_cnt, factor_cnt, mismatch_cnt);
    if (mismatch_cnt == 0 && expected_factors.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
